@@ design/frtic_pkg.sv @@
// Package: operation codes and clip-bound register indices for the round and clamp pipeline.
package frtic_pkg;
    typedef enum logic [2:0] {
        OP_FLOOR = 3'd0,
        OP_CEIL  = 3'd1,
        OP_ROUND = 3'd2,
        OP_TRUNC = 3'd3,
        OP_CLIP  = 3'd4
    } t_op;

    typedef enum logic [0:0] {
        REG_CLIP_LOW  = 1'b0,
        REG_CLIP_HIGH = 1'b1
    } t_reg;
endpackage

@@ design/fp_round_to_integral_and_clamp.sv @@
// Round-to-integral and clamp pipeline for binary32/binary64 values.
// Three register stages, one word per cycle while o_stall is low: stage 1
// decodes and builds the fraction mask and order keys, stage 2 does the
// increment and the key compares, stage 3 selects and holds the result. A
// stall freezes all stages at once, so nothing is lost or repeated.
module fp_round_to_integral_and_clamp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic        i_is_double,
    input  logic [63:0] i_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result
);
    import frtic_pkg::*;

    logic [63:0] r_lo, r_hi;
    logic        adv;
    logic        r_v1, r_v2, r_v3;

    assign o_cfg_ready = 1'b1;
    assign adv     = !(r_v3 && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_CLIP_LOW) r_lo <= i_cfg_data;
            else r_hi <= i_cfg_data;
        end
    end

    // stage 1 decode
    logic [63:0] s_all, s_sgnm, s_x, s_l, s_h, s_mask, s_one;
    logic        s_neg, s_einf, s_zero, s_big, s_small, s_half, s_xn, s_ln, s_hn;
    logic [10:0] s_e;
    logic [63:0] s_qb;
    logic [11:0] s_fb;

    always_comb begin
        s_all  = i_is_double ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        s_sgnm = i_is_double ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        s_qb   = i_is_double ? 64'h0008_0000_0000_0000 : 64'h0000_0000_0040_0000;
        s_one  = i_is_double ? 64'h3FF0_0000_0000_0000 : 64'h0000_0000_3F80_0000;
        s_x = i_value & s_all;
        s_l = r_lo & s_all;
        s_h = r_hi & s_all;
        s_e = i_is_double ? s_x[62:52] : {3'b000, s_x[30:23]};
        s_neg = (s_x & s_sgnm) != 64'd0;
        s_einf = i_is_double ? (s_e == 11'h7FF) : (s_e == 11'h0FF);
        s_zero = (s_x & ~s_sgnm) == 64'd0;
        s_big  = i_is_double ? (s_e >= 11'd1075) : (s_e >= 11'd150);
        s_small = i_is_double ? (s_e < 11'd1023) : (s_e < 11'd127);
        s_half  = i_is_double ? (s_e == 11'd1022) : (s_e == 11'd126);
        s_fb = i_is_double ? (12'd1075 - {1'b0, s_e}) : (12'd150 - {1'b0, s_e});
        s_mask = (64'd1 << s_fb[5:0]) - 64'd1;
        s_xn = i_is_double ? (s_x[62:52] == 11'h7FF && s_x[51:0] != 52'd0)
                           : (s_x[30:23] == 8'hFF && s_x[22:0] != 23'd0);
        s_ln = i_is_double ? (s_l[62:52] == 11'h7FF && s_l[51:0] != 52'd0)
                           : (s_l[30:23] == 8'hFF && s_l[22:0] != 23'd0);
        s_hn = i_is_double ? (s_h[62:52] == 11'h7FF && s_h[51:0] != 52'd0)
                           : (s_h[30:23] == 8'hFF && s_h[22:0] != 23'd0);
    end

    function automatic logic [63:0] f_key(input logic [63:0] b, input logic [63:0] sm);
        logic [63:0] mag;
        mag = b & ~sm;
        return ((b & sm) != 64'd0) ? (64'h8000_0000_0000_0000 - mag)
                                   : (64'h8000_0000_0000_0000 + mag);
    endfunction

    logic [2:0]  r1_op;
    logic [63:0] r1_all, r1_sgnm, r1_x, r1_l, r1_h, r1_mask, r1_one, r1_qb, r1_kx, r1_kl, r1_kh;
    logic        r1_neg, r1_einf, r1_zero, r1_big, r1_small, r1_half, r1_xn, r1_ln, r1_hn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= i_valid;
        if (adv) begin
            r1_op <= i_operation; r1_all <= s_all; r1_sgnm <= s_sgnm; r1_x <= s_x;
            r1_l <= s_l; r1_h <= s_h; r1_mask <= s_mask; r1_one <= s_one; r1_qb <= s_qb;
            r1_kx <= f_key(s_x, s_sgnm); r1_kl <= f_key(s_l, s_sgnm);
            r1_kh <= f_key(s_h, s_sgnm);
            r1_neg <= s_neg; r1_einf <= s_einf; r1_zero <= s_zero; r1_big <= s_big;
            r1_small <= s_small; r1_half <= s_half; r1_xn <= s_xn; r1_ln <= s_ln;
            r1_hn <= s_hn;
        end
    end

    // stage 2 round candidate and compares
    logic [63:0] n2_rnd, s_base, s_up, s_sg;
    always_comb begin
        s_base = r1_x & ~r1_mask;
        s_up   = s_base + r1_mask + 64'd1;
        s_sg   = r1_x & r1_sgnm;
        if (r1_einf) n2_rnd = r1_xn ? (r1_x | r1_qb) : r1_x;
        else if (r1_zero || r1_big) n2_rnd = r1_x;
        else if (r1_small) begin
            case (r1_op)
                OP_FLOOR: n2_rnd = r1_neg ? (s_sg | r1_one) : 64'd0;
                OP_CEIL:  n2_rnd = r1_neg ? s_sg : r1_one;
                OP_ROUND: n2_rnd = r1_half ? (s_sg | r1_one) : s_sg;
                default:  n2_rnd = s_sg;
            endcase
        end else if ((r1_x & r1_mask) == 64'd0) n2_rnd = r1_x;
        else begin
            case (r1_op)
                OP_FLOOR: n2_rnd = r1_neg ? s_up : s_base;
                OP_CEIL:  n2_rnd = r1_neg ? s_base : s_up;
                OP_ROUND: n2_rnd = (r1_x + ((r1_mask >> 1) + 64'd1)) & ~r1_mask;
                default:  n2_rnd = s_base;
            endcase
        end
    end

    logic [2:0]  r2_op;
    logic [63:0] r2_rnd, r2_x, r2_l, r2_h, r2_qb, r2_all;
    logic        r2_xn, r2_ln, r2_hn, r2_gtl, r2_lth, r2_geh, r2_lel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
        if (adv) begin
            r2_op <= r1_op; r2_rnd <= n2_rnd; r2_x <= r1_x; r2_l <= r1_l; r2_h <= r1_h;
            r2_qb <= r1_qb; r2_all <= r1_all;
            r2_xn <= r1_xn; r2_ln <= r1_ln; r2_hn <= r1_hn;
            r2_gtl <= r1_kx > r1_kl; r2_lth <= r1_kx < r1_kh;
            r2_geh <= r1_kx >= r1_kh; r2_lel <= r1_kx <= r1_kl;
        end
    end

    // stage 3 select
    logic [63:0] n3_res, s_clip;
    always_comb begin
        if (r2_xn) s_clip = r2_x | r2_qb;
        else if (!r2_ln && !r2_hn && r2_gtl && r2_lth) s_clip = r2_x;
        else if (!r2_hn && r2_geh) s_clip = r2_h;
        else if (!r2_ln && r2_lel) s_clip = r2_l;
        else if (r2_ln) s_clip = r2_l | r2_qb;
        else s_clip = r2_h | r2_qb;
        case (r2_op) inside
            OP_FLOOR, OP_CEIL, OP_ROUND, OP_TRUNC: n3_res = r2_rnd;
            OP_CLIP: n3_res = s_clip;
            default: n3_res = r2_x;
        endcase
        n3_res = n3_res & r2_all;
    end

    logic [63:0] r3_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (adv) r_v3 <= r_v2;
        if (adv) r3_res <= n3_res;
    end
    assign o_result = r3_res;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_stall) |=> (r_v3 && $stable(r3_res))) else $error("held word changed");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_v2) |=> r_v3) else $error("word lost in pipe");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v3 && i_stall)) else $error("spurious stall");
endmodule
